// File: rtl/bsr_pkg.sv
package bsr_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BITS  = 64;
  localparam int DEPTH     = 64;
  localparam int ADDR_W    = 6;
  localparam int ROW_W     = ADDR_W - 1;
  localparam int BANK_ROWS = DEPTH / 2;
  localparam int CNT_W     = ADDR_W + 1;
  localparam int PC_W      = 3;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [63:0]         pay;
  } rec_t;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SETUP,
    OP_PAD,
    OP_SINIT,
    OP_EXCH,
    OP_NEXT,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_SMALL,
    COND_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   tgt;
  } ctrl_t;

  localparam pc_t PC_LOAD  = 3'd0;
  localparam pc_t PC_SETUP = 3'd1;
  localparam pc_t PC_PAD   = 3'd2;
  localparam pc_t PC_SINIT = 3'd3;
  localparam pc_t PC_EXCH  = 3'd4;
  localparam pc_t PC_NEXT  = 3'd5;
  localparam pc_t PC_EMIT  = 3'd6;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t cw;
    case (pc)
      PC_LOAD:  cw = '{op: OP_LOAD,  cond: COND_NEVER,  tgt: PC_LOAD};
      PC_SETUP: cw = '{op: OP_SETUP, cond: COND_NEVER,  tgt: PC_LOAD};
      PC_PAD:   cw = '{op: OP_PAD,   cond: COND_NEVER,  tgt: PC_LOAD};
      PC_SINIT: cw = '{op: OP_SINIT, cond: COND_SMALL,  tgt: PC_EMIT};
      PC_EXCH:  cw = '{op: OP_EXCH,  cond: COND_NEVER,  tgt: PC_LOAD};
      PC_NEXT:  cw = '{op: OP_NEXT,  cond: COND_MORE,   tgt: PC_EXCH};
      PC_EMIT:  cw = '{op: OP_EMIT,  cond: COND_ALWAYS, tgt: PC_LOAD};
      default:  cw = '{op: OP_LOAD,  cond: COND_ALWAYS, tgt: PC_LOAD};
    endcase
    return cw;
  endfunction

  function automatic logic [CNT_W-1:0] next_pow2(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] p;
    p = CNT_W'(1);
    for (int i = 0; i < ADDR_W; i++) begin
      if (p < n) p = p << 1;
    end
    return p;
  endfunction

endpackage

// File: rtl/bitonic_sort_records_unit.sv
// channel | signals                                   | word
// --------+-------------------------------------------+-------------------------------
// in      | in_valid_i / in_ready_o                   | key_i, payload_i, last_i
// out     | out_valid_o / out_ready_i                 | key_res_o, payload_res_o,
//         |                                           | last_res_o, overflow_o
// One input word per cycle while loading; the set sorts after the word with last_i.
// Sort of n words: setup, then padding up to P, the padded size, then init; each stage runs
// its exchanges and then a next step; one exchange per cycle, two banks.
// Emit: one word per cycle from the bank read registers, stalled by out_ready_i.
// Setup waits until the previous set's final word has left the output register.
// rst_ni clears the sequencer, record count, overflow and valid flags; the store has no reset.
module bitonic_sort_records_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] key_i,
  input  logic [63:0] payload_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] key_res_o,
  output logic [63:0] payload_res_o,
  output logic        last_res_o,
  output logic        overflow_o
);
  import bsr_pkg::*;

  rec_t mem0_q [BANK_ROWS];
  rec_t mem1_q [BANK_ROWS];
  rec_t rd0_q, rd1_q;

  pc_t               pc_q, pc_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W-1:0]  padded_q, padded_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ROW_W-1:0]  pair_q, pair_d;
  logic [ADDR_W-1:0] chunk_q, chunk_d;
  logic [ADDR_W-1:0] dist_q, dist_d;
  logic              x_valid_q, x_valid_d;
  logic [ADDR_W-1:0] x_a_q, x_a_d;
  logic [ADDR_W-1:0] x_b_q, x_b_d;
  logic              x_asc_q, x_asc_d;
  logic              ov_q, ov_d;
  logic              out_bank_q, out_bank_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;

  ctrl_t             cw;
  logic              in_acc, issue, hold, jump, more;
  logic [ADDR_W-1:0] low, pair6, addr_a, addr_b;
  logic [CNT_W-1:0]  nchunk;
  logic [ROW_W-1:0]  last_pair;
  logic              asc;
  rec_t              rec_a, rec_b, new_a, new_b, out_rec;
  logic              swap;

  logic              we0, we1, re;
  logic [ROW_W-1:0]  wa0, wa1, ra0, ra1;
  rec_t              wd0, wd1, ld_rec, pad_rec;

  assign cw         = ucode(pc_q);
  assign in_ready_o = (cw.op == OP_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign issue      = (cw.op == OP_EMIT) && (!ov_q || out_ready_i);

  assign pair6     = {1'b0, pair_q};
  assign low       = dist_q - ADDR_W'(1);
  assign addr_a    = (pair6 & low) | ((pair6 & ~low) << 1);
  assign addr_b    = addr_a | dist_q;
  assign asc       = (pair6 & chunk_q) == '0;
  assign last_pair = ROW_W'(padded_q[CNT_W-1:1] - (CNT_W-1)'(1));
  assign nchunk    = {chunk_q, 1'b0};
  assign more      = (dist_q > ADDR_W'(1)) || (nchunk < padded_q);

  assign rec_a = (^x_a_q) ? rd1_q : rd0_q;
  assign rec_b = (^x_a_q) ? rd0_q : rd1_q;
  assign swap  = (rec_a.key > rec_b.key) == x_asc_q;
  assign new_a = swap ? rec_b : rec_a;
  assign new_b = swap ? rec_a : rec_b;

  assign ld_rec  = '{key: key_i[KEY_BITS-1:0], pay: payload_i};
  assign pad_rec = '{key: '1, pay: '1};

  // bank select is address parity: a compare pair always spans both banks
  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa0 = '0;
    wa1 = '0;
    wd0 = ld_rec;
    wd1 = ld_rec;
    if (x_valid_q) begin
      we0 = 1'b1;
      we1 = 1'b1;
      wa0 = (^x_a_q) ? x_b_q[ADDR_W-1:1] : x_a_q[ADDR_W-1:1];
      wa1 = (^x_a_q) ? x_a_q[ADDR_W-1:1] : x_b_q[ADDR_W-1:1];
      wd0 = (^x_a_q) ? new_b : new_a;
      wd1 = (^x_a_q) ? new_a : new_b;
    end else if (cw.op == OP_LOAD) begin
      if (in_acc && (count_q < CNT_W'(CAPACITY))) begin
        we0 = ~(^count_q[ADDR_W-1:0]);
        we1 = ^count_q[ADDR_W-1:0];
      end
      wa0 = count_q[ADDR_W-1:1];
      wa1 = count_q[ADDR_W-1:1];
    end else if (cw.op == OP_PAD) begin
      if (idx_q < padded_q) begin
        we0 = ~(^idx_q[ADDR_W-1:0]);
        we1 = ^idx_q[ADDR_W-1:0];
      end
      wa0 = idx_q[ADDR_W-1:1];
      wa1 = idx_q[ADDR_W-1:1];
      wd0 = pad_rec;
      wd1 = pad_rec;
    end
  end

  always_comb begin
    re  = 1'b0;
    ra0 = idx_q[ADDR_W-1:1];
    ra1 = idx_q[ADDR_W-1:1];
    if (cw.op == OP_EXCH) begin
      re  = 1'b1;
      ra0 = (^addr_a) ? addr_b[ADDR_W-1:1] : addr_a[ADDR_W-1:1];
      ra1 = (^addr_a) ? addr_a[ADDR_W-1:1] : addr_b[ADDR_W-1:1];
    end else if (issue) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) mem0_q[wa0] <= wd0;
    if (re) rd0_q <= mem0_q[ra0];
  end

  always_ff @(posedge clk_i) begin
    if (we1) mem1_q[wa1] <= wd1;
    if (re) rd1_q <= mem1_q[ra1];
  end

  // sequencer and datapath next state
  always_comb begin
    pc_d       = pc_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    padded_d   = padded_q;
    idx_d      = idx_q;
    pair_d     = pair_q;
    chunk_d    = chunk_q;
    dist_d     = dist_q;
    x_valid_d  = 1'b0;
    x_a_d      = addr_a;
    x_b_d      = addr_b;
    x_asc_d    = asc;
    ov_d       = ov_q;
    out_bank_d = out_bank_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    hold       = 1'b0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (cw.op)
      OP_LOAD: begin
        hold = !(in_acc && last_i);
        if (in_acc) begin
          if (count_q < CNT_W'(CAPACITY)) count_d = count_q + CNT_W'(1);
          else ovf_d = 1'b1;
        end
      end
      OP_SETUP: begin
        hold     = ov_q;
        padded_d = next_pow2(count_q);
        idx_d    = count_q;
      end
      OP_PAD: begin
        hold  = (idx_q + CNT_W'(1)) < padded_q;
        idx_d = idx_q + CNT_W'(1);
      end
      OP_SINIT: begin
        chunk_d = ADDR_W'(1);
        dist_d  = ADDR_W'(1);
        pair_d  = '0;
        idx_d   = '0;
      end
      OP_EXCH: begin
        x_valid_d = 1'b1;
        hold      = (pair_q != last_pair);
        pair_d    = hold ? pair_q + ROW_W'(1) : '0;
      end
      OP_NEXT: begin
        idx_d = '0;
        if (dist_q > ADDR_W'(1)) begin
          dist_d = dist_q >> 1;
        end else if (more) begin
          chunk_d = nchunk[ADDR_W-1:0];
          dist_d  = nchunk[ADDR_W-1:0];
        end
      end
      OP_EMIT: begin
        hold = !(issue && (idx_q == count_q - CNT_W'(1)));
        if (issue) begin
          ov_d       = 1'b1;
          out_bank_d = ^idx_q[ADDR_W-1:0];
          out_last_d = (idx_q == count_q - CNT_W'(1));
          out_ovf_d  = ovf_q;
          idx_d      = idx_q + CNT_W'(1);
        end
        if (!hold) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        hold = 1'b0;
      end
    endcase

    case (cw.cond)
      COND_ALWAYS: jump = 1'b1;
      COND_SMALL:  jump = padded_q < CNT_W'(2);
      COND_MORE:   jump = more;
      default:     jump = 1'b0;
    endcase

    if (!hold) pc_d = jump ? cw.tgt : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= PC_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      x_valid_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      pc_q      <= pc_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      x_valid_q <= x_valid_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    padded_q   <= padded_d;
    idx_q      <= idx_d;
    pair_q     <= pair_d;
    chunk_q    <= chunk_d;
    dist_q     <= dist_d;
    x_a_q      <= x_a_d;
    x_b_q      <= x_b_d;
    x_asc_q    <= x_asc_d;
    out_bank_q <= out_bank_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_rec       = out_bank_q ? rd1_q : rd0_q;
  assign out_valid_o   = ov_q;
  assign key_res_o     = 64'(out_rec.key);
  assign payload_res_o = out_rec.pay;
  assign last_res_o    = out_last_q;
  assign overflow_o    = out_ovf_q;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_xwrite_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_valid_q |-> (cw.op == OP_EXCH || cw.op == OP_NEXT))
    else $error("exchange write outside sort");

  a_sort_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op == OP_EXCH) |-> !ov_q)
    else $error("sort would clobber pending output word");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op == OP_EMIT) |-> (idx_q < count_q))
    else $error("emit index past record count");

  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.op == OP_EMIT && !hold) |=> (count_q == '0 && !ovf_q && pc_q == PC_LOAD))
    else $error("set state not cleared after emit");
`endif

endmodule

// File: bench/testbench.sv
module testbench;
  import bsr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int RANDOM_WORDS    = 110;

  typedef enum int {KEYS_WIDE, KEYS_TIED, KEYS_EDGE} key_mode_e;
  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    rec_t rec;
    logic last;
    logic ovf;
  } sorted_word_t;

  class sort_scoreboard;
    rec_t         held[$];
    bit           dropped;
    sorted_word_t expected[$];
    int           errors;
    int           sets;
    int           overflow_sets;
    int           checked;

    function new();
      dropped       = 1'b0;
      errors        = 0;
      sets          = 0;
      overflow_sets = 0;
      checked       = 0;
    endfunction

    // Collects one record; on the closing word, pads, runs the bitonic
    // network and queues the sorted words.
    function void note_input(logic [63:0] key, logic [63:0] pay, logic last);
      rec_t r;
      rec_t t;
      rec_t work [DEPTH];
      int   n, padded, chunk, span, pair, low_bits, a, b;
      bit   ascend;
      r.key = key[KEY_BITS-1:0];
      r.pay = pay;
      if (held.size() < CAPACITY) held.push_back(r);
      else dropped = 1'b1;
      if (!last) return;
      n = held.size();
      padded = 1;
      while (padded < n) padded = padded << 1;
      for (int i = 0; i < DEPTH; i++) work[i] = (i < n) ? held[i] : '1;
      for (chunk = 1; chunk < padded; chunk = chunk << 1) begin
        for (span = chunk; span > 0; span = span >> 1) begin
          for (pair = 0; pair < padded / 2; pair++) begin
            ascend   = (pair & chunk) == 0;
            low_bits = span - 1;
            a = ((pair & low_bits) | ((pair & ~low_bits) << 1)) & (DEPTH - 1);
            b = (a | span) & (DEPTH - 1);
            if ((work[a].key > work[b].key) == ascend) begin
              t       = work[a];
              work[a] = work[b];
              work[b] = t;
            end
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        expected.push_back('{rec: work[i], last: (i == n - 1), ovf: dropped});
      end
      sets++;
      if (dropped) overflow_sets++;
      held.delete();
      dropped = 1'b0;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check(logic [63:0] key, logic [63:0] pay, logic last, logic ovf);
      sorted_word_t e;
      checked++;
      if (expected.size() == 0) begin
        report($sformatf("output word %0d with nothing pending, key %h", checked, key));
        return;
      end
      e = expected.pop_front();
      if (key !== 64'(e.rec.key))
        report($sformatf("word %0d key_res %h, want %h", checked, key, e.rec.key));
      if (pay !== e.rec.pay)
        report($sformatf("word %0d payload_res %h, want %h", checked, pay, e.rec.pay));
      if (last !== e.last)
        report($sformatf("word %0d last_res %b, want %b", checked, last, e.last));
      if (ovf !== e.ovf)
        report($sformatf("word %0d overflow %b, want %b", checked, ovf, e.ovf));
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [63:0] key_i       = '0;
  logic [63:0] payload_i   = '0;
  logic        last_i      = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [63:0] key_res_o;
  logic [63:0] payload_res_o;
  logic        last_res_o;
  logic        overflow_o;

  sort_scoreboard sb = new();
  int burst_left = 0;
  int words_sent = 0;
  int max_set    = 0;

  bitonic_sort_records_unit dut (.*);

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  function automatic logic [63:0] pick_key(key_mode_e mode);
    logic [63:0] k;
    case (mode)
      KEYS_TIED: k = ($urandom_range(0, 3) == 3) ? '1 : 64'($urandom_range(0, 2));
      KEYS_EDGE: begin
        case ($urandom_range(0, 4))
          0:       k = '0;
          1:       k = '1;
          2:       k = 64'd1 << $urandom_range(0, 63);
          3:       k = ~(64'd1 << $urandom_range(0, 63));
          default: k = '1 - 64'($urandom_range(0, 3));
        endcase
      end
      default:   k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  function automatic logic [63:0] pick_payload();
    return ($urandom_range(0, 15) == 0) ? '1 : {$urandom, $urandom};
  endfunction

  task automatic send_word(input logic [63:0] k, input logic [63:0] p, input logic l);
    in_valid_i <= 1'b1;
    key_i      <= k;
    payload_i  <= p;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(k, p, l);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_set(input int size, input key_mode_e mode);
    for (int i = 0; i < size; i++) send_word(pick_key(mode), pick_payload(), i == size - 1);
    if (size > max_set) max_set = size;
  endtask

  initial begin : stimulus
    int        set_no;
    int        start_words;
    int        size;
    int        pick;
    key_mode_e mode;
    set_no = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // single records at both key extremes
    send_word('0, '0, 1'b1);
    send_word('1, '1, 1'b1);
    // pair in descending order
    send_word(64'h8000_0000_0000_0000, 64'd1, 1'b0);
    send_word(64'd1, '1, 1'b1);
    // real all-ones keys next to a filler record
    send_word('1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(64'd5, 64'h5555_5555_5555_5555, 1'b0);
    send_word('1, 64'h0123_4567_89AB_CDEF, 1'b1);
    // all keys equal
    for (int i = 0; i < 5; i++) send_word(64'd7, 64'(i + 100), i == 4);
    // mixed extremes, full power of two
    send_word(64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1'b0);
    send_word('0, '1, 1'b0);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b0);
    send_word(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'd1, 64'hDEAD_BEEF_0000_0001, 1'b0);
    send_word('1, 64'd2, 1'b0);
    send_word(64'h0000_0001_0000_0000, 64'd3, 1'b0);
    send_word('0, 64'd4, 1'b1);
    if (max_set < 8) max_set = 8;

    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      mode = key_mode_e'($urandom_range(0, 2));
      if (set_no == 1) begin
        size = CAPACITY + $urandom_range(1, 3);
      end else if (set_no == 3) begin
        size = CAPACITY;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      size = $urandom_range(1, 8);
        else if (pick < 9) size = $urandom_range(9, 20);
        else               size = $urandom_range(21, 40);
      end
      send_set(size, mode);
      set_no++;
    end
    in_valid_i <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.held.size() != 0) sb.report("records left in an unclosed set");
    $display("%0d sets sorted (largest %0d records, %0d cut at capacity)",
             sb.sets, max_set, sb.overflow_sets);
    $display("%0d input words sent, %0d output words checked", words_sent, sb.checked);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin : receiver
    int       mode_left;
    int       phase;
    bit       held_off;
    rx_mode_e rx_mode;
    mode_left = 0;
    phase     = 0;
    held_off  = 1'b0;
    rx_mode   = RX_OPEN;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check(key_res_o, payload_res_o, last_res_o, overflow_o);
      if (!held_off && sb.checked >= 40) begin
        // long hold-off so the sorter backs up into its input
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        phase++;
        case (rx_mode)
          RX_OPEN:   out_ready_i <= 1'b1;
          RX_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= (phase % 7) < 4;
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles with no word moving", quiet);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
